// ----- design/c2d_pkg.sv -----
// Shared constants, types and helpers for the convolution block.
`default_nettype none
package c2d_pkg;

  localparam int MAX_IN_CH  = 16;
  localparam int MAX_OUT_CH = 16;
  localparam int MAX_KERNEL = 5;
  localparam int MAX_HEIGHT = 32;
  localparam int MAX_WIDTH  = 32;

  localparam int W_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
  localparam int B_DEPTH = MAX_OUT_CH;
  localparam int A_DEPTH = MAX_IN_CH * MAX_HEIGHT * MAX_WIDTH;

  localparam int WA_W = $clog2(W_DEPTH);
  localparam int AA_W = $clog2(A_DEPTH);
  localparam int BA_W = $clog2(B_DEPTH);
  localparam int IC_W = $clog2(MAX_IN_CH);
  localparam int K_W  = $clog2(MAX_KERNEL);
  localparam int Y_W  = $clog2(MAX_HEIGHT);
  localparam int X_W  = $clog2(MAX_WIDTH);

  localparam int OP_W   = 3;
  localparam int ADDR_W = 14;
  localparam int OC_W   = 4;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 5;
  localparam int VAL_W  = 16;
  localparam int RES_W  = 32;
  localparam int FRAC   = 12;

  localparam logic [OP_W-1:0] OP_LOAD_W   = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B   = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_A   = 3'd2;
  localparam logic [OP_W-1:0] OP_FORWARD  = 3'd3;
  localparam logic [OP_W-1:0] OP_BACKWARD = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_WG  = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_BG  = 3'd6;
  localparam logic [OP_W-1:0] OP_READ_XG  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_CH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KSIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd5;

  // Effective (limited) configuration.
  typedef struct packed {
    logic [4:0] nic;
    logic [4:0] noc;
    logic [2:0] k;
    logic [2:0] pad;
    logic [5:0] h;
    logic [5:0] w;
  } cfg_t;

  typedef struct packed {
    logic            accept;
    logic            tap_valid;
    logic [IC_W-1:0] ic;
    logic [K_W-1:0]  ky;
    logic [K_W-1:0]  kx;
    logic            clr_we;
    logic [AA_W-1:0] clr_addr;
    logic            bg_clear;
    logic            push;
  } cmd_t;

  typedef struct packed {
    logic pos_ok;
    logic busy;
    logic out_free;
  } sts_t;

  function automatic logic signed [RES_W-1:0] sat_add(input logic signed [RES_W-1:0] a,
                                                      input logic signed [RES_W-1:0] b);
    logic signed [RES_W:0] s;
    s = {a[RES_W-1], a} + {b[RES_W-1], b};
    if (s[RES_W] != s[RES_W-1]) begin
      return s[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end
    return s[RES_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/c2d_in_if.sv -----
// Input item channel: operation and its operands.
`default_nettype none
interface c2d_in_if import c2d_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [ADDR_W-1:0]       address;
  logic                    clear_flag;
  logic [OC_W-1:0]         out_channel;
  logic [ROW_W-1:0]        row;
  logic [COL_W-1:0]        col;
  logic signed [VAL_W-1:0] value;
  modport source(output valid, operation, address, clear_flag, out_channel, row, col, value,
                 input ready);
  modport sink(input valid, operation, address, clear_flag, out_channel, row, col, value,
               output ready);
endinterface
`default_nettype wire

// ----- design/c2d_out_if.sv -----
// Result channel: one Q8.24 word per beat.
`default_nettype none
interface c2d_out_if import c2d_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  modport source(output valid, result_value, input ready);
  modport sink(input valid, result_value, output ready);
endinterface
`default_nettype wire

// ----- design/c2d_ctrl.sv -----
// Controller: item dispatch, tap walk counters, gradient clear sweep.
`default_nettype none
module c2d_ctrl import c2d_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [OP_W-1:0] op_i,
  input  wire logic            clear_flag_i,
  input  wire cfg_t            cfg_i,
  input  wire sts_t            sts_i,
  output logic                 in_ready_o,
  output cmd_t                 cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [IC_W-1:0] ic_q, ic_d;
  logic [K_W-1:0]  ky_q, ky_d, kx_q, kx_d;
  logic [AA_W-1:0] clr_q, clr_d;
  logic            back_q, back_d;
  logic            accept, no_taps, last_kx, last_ky, last_ic;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign no_taps    = (cfg_i.nic == 5'd0) || (cfg_i.k == 3'd0);
  assign last_kx    = (kx_q == cfg_i.k - 3'd1);
  assign last_ky    = (ky_q == cfg_i.k - 3'd1);
  assign last_ic    = ({1'b0, ic_q} == cfg_i.nic - 5'd1);

  always_comb begin
    state_d = state_q;
    ic_d    = ic_q;
    ky_d    = ky_q;
    kx_d    = kx_q;
    clr_d   = clr_q;
    back_d  = back_q;
    cmd_o   = '0;
    cmd_o.accept   = accept;
    cmd_o.ic       = ic_q;
    cmd_o.ky       = ky_q;
    cmd_o.kx       = kx_q;
    cmd_o.clr_addr = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AA_W'(A_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ic_d = '0;
        ky_d = '0;
        kx_d = '0;
        if (accept) begin
          back_d = (op_i == OP_BACKWARD);
          case (op_i) inside
            OP_FORWARD:  state_d = (sts_i.pos_ok && !no_taps) ? ST_WALK : ST_FIN;
            OP_BACKWARD: state_d = (sts_i.pos_ok && !no_taps) ? ST_WALK : ST_IDLE;
            OP_READ_WG, OP_READ_BG: state_d = ST_FIN;
            OP_READ_XG: begin
              if (clear_flag_i) begin
                cmd_o.bg_clear = 1'b1;
                clr_d   = '0;
                state_d = ST_CLEAR;
              end else begin
                state_d = ST_FIN;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        cmd_o.tap_valid = 1'b1;
        kx_d = kx_q + 1'b1;
        if (last_kx) begin
          kx_d = '0;
          ky_d = ky_q + 1'b1;
          if (last_ky) begin
            ky_d = '0;
            ic_d = ic_q + 1'b1;
            if (last_ic) begin
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = back_q ? ST_IDLE : ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ic_q    <= '0;
      ky_q    <= '0;
      kx_q    <= '0;
      clr_q   <= '0;
      back_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ic_q    <= ic_d;
      ky_q    <= ky_d;
      kx_q    <= kx_d;
      clr_q   <= clr_d;
      back_q  <= back_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/c2d_dp.sv -----
// Datapath: stores, tap pipeline (address, read, multiply, accumulate) and result register.
`default_nettype none
module c2d_dp import c2d_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cmd_t                    cmd_i,
  input  wire cfg_t                    cfg_i,
  input  wire logic [OP_W-1:0]         op_i,
  input  wire logic [ADDR_W-1:0]       addr_i,
  input  wire logic [OC_W-1:0]         oc_i,
  input  wire logic [ROW_W-1:0]        row_i,
  input  wire logic [COL_W-1:0]        col_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic signed [RES_W-1:0]      out_data_o,
  output sts_t                         sts_o
);

  logic [VAL_W-1:0] wmem  [W_DEPTH];
  logic [VAL_W-1:0] amem  [A_DEPTH];
  logic [VAL_W-1:0] bmem  [B_DEPTH];
  logic [RES_W-1:0] wgmem [W_DEPTH];
  logic [RES_W-1:0] igmem [A_DEPTH];
  logic [RES_W-1:0] bgrad_q [B_DEPTH];

  logic [OP_W-1:0]         op_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [OC_W-1:0]         oc_q;
  logic [ROW_W-1:0]        row_q;
  logic [COL_W-1:0]        col_q;
  logic signed [VAL_W-1:0] g_q;
  logic                    pos_q;
  logic                    back;

  logic signed [7:0] iy, ix;
  logic              inb;
  logic [WA_W-1:0]   wi, wg_ra;
  logic [AA_W-1:0]   ai, ig_ra;

  logic                    s1_run_q, s1_ok_q, s2_run_q, s2_ok_q;
  logic [WA_W-1:0]         s1_wi_q, s2_wi_q;
  logic [AA_W-1:0]         s1_ai_q, s2_ai_q;
  logic signed [VAL_W-1:0] w_rd_q, a_rd_q, mul_b;
  logic signed [RES_W-1:0] wg_rd_q, ig_rd_q, wg2_q, ig2_q;
  logic signed [RES_W-1:0] m1_d, m2_d, m1_q, m2_q;
  logic signed [RES_W-1:0] acc_q, res;
  logic signed [RES_W-1:0] g_ext;

  logic w_we, b_we, a_we, bg_upd, wg_we, ig_we;

  assign back  = (op_q == OP_BACKWARD);
  assign g_ext = {{(RES_W - VAL_W - FRAC){value_i[VAL_W-1]}}, value_i, {FRAC{1'b0}}};

  assign sts_o.pos_ok = ({1'b0, oc_i} < cfg_i.noc) && ({1'b0, row_i} < cfg_i.h)
                        && ({1'b0, col_i} < cfg_i.w);
  assign sts_o.busy     = s1_run_q || s2_run_q;
  assign sts_o.out_free = !out_valid_o || out_ready_i;

  assign w_we   = cmd_i.accept && (op_i == OP_LOAD_W) && (int'(addr_i) < W_DEPTH);
  assign b_we   = cmd_i.accept && (op_i == OP_LOAD_B) && (int'(addr_i) < B_DEPTH);
  assign a_we   = cmd_i.accept && (op_i == OP_LOAD_A) && (int'(addr_i) < A_DEPTH);
  assign bg_upd = cmd_i.accept && (op_i == OP_BACKWARD) && sts_o.pos_ok;

  // Tap coordinates and flat addresses.
  always_comb begin
    iy  = $signed({3'b000, row_q}) + $signed({5'b00000, cmd_i.ky}) - $signed({5'b00000, cfg_i.pad});
    ix  = $signed({3'b000, col_q}) + $signed({5'b00000, cmd_i.kx}) - $signed({5'b00000, cfg_i.pad});
    inb = !iy[7] && !ix[7] && (iy < $signed({2'b00, cfg_i.h})) && (ix < $signed({2'b00, cfg_i.w}));
    wi  = WA_W'((int'(oc_q) * MAX_IN_CH + int'(cmd_i.ic)) * (MAX_KERNEL * MAX_KERNEL)
                + int'(cmd_i.ky) * MAX_KERNEL + int'(cmd_i.kx));
    ai  = AA_W'(int'(cmd_i.ic) * (MAX_HEIGHT * MAX_WIDTH)
                + int'(iy[Y_W-1:0]) * MAX_WIDTH + int'(ix[X_W-1:0]));
    if (cmd_i.tap_valid) begin
      wg_ra = wi;
      ig_ra = ai;
    end else if (cmd_i.accept) begin
      wg_ra = addr_i[WA_W-1:0];
      ig_ra = addr_i[AA_W-1:0];
    end else begin
      wg_ra = addr_q[WA_W-1:0];
      ig_ra = addr_q[AA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem[addr_i[WA_W-1:0]] <= value_i;
    end
    w_rd_q <= wmem[wi];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      amem[addr_i[AA_W-1:0]] <= value_i;
    end
    a_rd_q <= amem[ai];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bmem[addr_i[BA_W-1:0]] <= value_i;
    end
  end

  assign wg_we = s2_run_q && s2_ok_q && back;
  assign ig_we = wg_we;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we && (int'(cmd_i.clr_addr) < W_DEPTH)) begin
      wgmem[cmd_i.clr_addr[WA_W-1:0]] <= '0;
    end else if (wg_we) begin
      wgmem[s2_wi_q] <= sat_add(wg2_q, m1_q);
    end
    wg_rd_q <= wgmem[wg_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we) begin
      igmem[cmd_i.clr_addr] <= '0;
    end else if (ig_we) begin
      igmem[s2_ai_q] <= sat_add(ig2_q, m2_q);
    end
    ig_rd_q <= igmem[ig_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < B_DEPTH; i++) begin
        bgrad_q[i] <= '0;
      end
    end else if (cmd_i.bg_clear) begin
      for (int i = 0; i < B_DEPTH; i++) begin
        bgrad_q[i] <= '0;
      end
    end else if (bg_upd) begin
      bgrad_q[oc_i] <= sat_add(bgrad_q[oc_i], g_ext);
    end
  end

  // Latch item operands.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_i;
      addr_q <= addr_i;
      oc_q   <= oc_i;
      row_q  <= row_i;
      col_q  <= col_i;
      g_q    <= value_i;
      pos_q  <= sts_o.pos_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_run_q <= 1'b0;
      s2_run_q <= 1'b0;
    end else begin
      s1_run_q <= cmd_i.tap_valid;
      s2_run_q <= s1_run_q;
    end
  end

  assign mul_b = back ? g_q : w_rd_q;
  assign m1_d  = a_rd_q * mul_b;
  assign m2_d  = w_rd_q * g_q;

  always_ff @(posedge clk_i) begin
    s1_ok_q <= inb;
    s1_wi_q <= wi;
    s1_ai_q <= ai;
    s2_ok_q <= s1_ok_q;
    s2_wi_q <= s1_wi_q;
    s2_ai_q <= s1_ai_q;
    wg2_q   <= wg_rd_q;
    ig2_q   <= ig_rd_q;
    m1_q    <= m1_d;
    m2_q    <= m2_d;
  end

  // Forward sum starts at the bias, then takes one product per in-bounds tap.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      acc_q <= {{(RES_W - VAL_W - FRAC){bmem[oc_i][VAL_W-1]}}, bmem[oc_i], {FRAC{1'b0}}};
    end else if (s2_run_q && s2_ok_q && !back) begin
      acc_q <= sat_add(acc_q, m1_q);
    end
  end

  always_comb begin
    case (op_q)
      OP_FORWARD: res = pos_q ? acc_q : '0;
      OP_READ_WG: res = (int'(addr_q) < W_DEPTH) ? wg_rd_q : '0;
      OP_READ_BG: res = (int'(addr_q) < B_DEPTH) ? bgrad_q[addr_q[BA_W-1:0]] : '0;
      default:    res = (int'(addr_q) < A_DEPTH) ? ig_rd_q : '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_data_o <= res;
    end
  end

endmodule
`default_nettype wire

// ----- design/conv2d_same_forward_backward.sv -----
// Stride-1 zero-padded 2D convolution with gradient pass: top level.
// Input channel in_item carries one operation per beat: load weight, bias or
// activation; forward point; backward point; read a gradient word; or clear.
// Output channel out_item carries one Q8.24 word for forward and read beats.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i), to be
// written only while the block is idle; the block itself does not enforce this.
// Flow per operation:
//   loads and backward out of range: next beat taken the next cycle.
//   reads: the finish state registers the result once the output register is free.
//   forward/backward: tap walk over in_channels * kernel_size^2 taps (one tap
//   per cycle through a 3-stage read/multiply/accumulate pipe), then a pipe
//   drain and, for forward, the load of the result register.
//   clear: a sweep of the gradient stores, one input-gradient entry per cycle.
// Reset: registers return to their defaults and a sweep zeroes the weight
// and input gradient stores; in_item.ready stays low meanwhile.
// A stalled receiver holds the result in the output register; the block then
// still takes further beats that produce no result, and holds at most one
// pending result behind the register.
`default_nettype none
module conv2d_same_forward_backward import c2d_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  c2d_in_if.sink                     in_item,
  c2d_out_if.source                  out_item,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [4:0] in_ch_q, out_ch_q;
  logic [2:0] ksize_q, pad_q;
  logic [5:0] height_q, width_q;
  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= 5'd1;
      out_ch_q <= 5'd1;
      ksize_q  <= 3'd3;
      pad_q    <= 3'd1;
      height_q <= 6'd32;
      width_q  <= 6'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IN_CH:  in_ch_q  <= cfg_data_i[4:0];
        CFG_OUT_CH: out_ch_q <= cfg_data_i[4:0];
        CFG_KSIZE:  ksize_q  <= cfg_data_i[2:0];
        CFG_PAD:    pad_q    <= cfg_data_i[2:0];
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_WIDTH:  width_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp registers to the store dimensions.
  always_comb begin
    cfg.nic = (int'(in_ch_q)  > MAX_IN_CH)  ? 5'(MAX_IN_CH)  : in_ch_q;
    cfg.noc = (int'(out_ch_q) > MAX_OUT_CH) ? 5'(MAX_OUT_CH) : out_ch_q;
    cfg.k   = (int'(ksize_q)  > MAX_KERNEL) ? 3'(MAX_KERNEL) : ksize_q;
    cfg.pad = pad_q;
    cfg.h   = (int'(height_q) > MAX_HEIGHT) ? 6'(MAX_HEIGHT) : height_q;
    cfg.w   = (int'(width_q)  > MAX_WIDTH)  ? 6'(MAX_WIDTH)  : width_q;
  end

  c2d_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_item.valid),
    .op_i         (in_item.operation),
    .clear_flag_i (in_item.clear_flag),
    .cfg_i        (cfg),
    .sts_i        (sts),
    .in_ready_o   (in_item.ready),
    .cmd_o        (cmd)
  );

  c2d_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .op_i        (in_item.operation),
    .addr_i      (in_item.address),
    .oc_i        (in_item.out_channel),
    .row_i       (in_item.row),
    .col_i       (in_item.col),
    .value_i     (in_item.value),
    .out_ready_i (out_item.ready),
    .out_valid_o (out_item.valid),
    .out_data_o  (out_item.result_value),
    .sts_o       (sts)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.tap_valid |-> !in_item.ready)
    else $error("tap walk overlaps item intake");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd.clr_we && cmd.tap_valid))
    else $error("clear sweep overlaps tap walk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd.push |-> (!out_item.valid || out_item.ready))
    else $error("result pushed over a pending beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.clr_we |-> !sts.busy)
    else $error("clear sweep while tap pipe busy");

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the convolution block: directed table, then random phases.
`timescale 1ns / 1ps
module tb;
  import c2d_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [ADDR_W-1:0]       addr;
    logic                    clr;
    logic [OC_W-1:0]         oc;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] val;
  } conv_item_t;

  typedef struct {
    conv_item_t              it;
    bit                      typed;
    logic signed [RES_W-1:0] typed_val;
  } table_row_t;

  typedef struct {
    int ic, oc, k, pad, h, w;
    int n_items;
    int span;
    bit idle;
  } phase_t;

  typedef enum {WALK_FWD, WALK_BWD, WALK_FILL} walk_mode_e;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int QUIET_LIMIT = 60000;
  localparam int IDLE_WAIT = 16500;
  localparam int HOLD_LEN = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_IN_CH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  c2d_in_if in_ch();
  c2d_out_if out_ch();

  conv2d_same_forward_backward DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_item(in_ch), .out_item(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the block's state.
  logic signed [VAL_W-1:0] weights_m [W_DEPTH];
  logic signed [VAL_W-1:0] bias_m [B_DEPTH];
  logic signed [VAL_W-1:0] acts_m [A_DEPTH];
  logic signed [RES_W-1:0] wgrad_m [W_DEPTH];
  logic signed [RES_W-1:0] bgrad_m [B_DEPTH];
  logic signed [RES_W-1:0] xgrad_m [A_DEPTH];
  bit w_wr [W_DEPTH];
  bit b_wr [B_DEPTH];
  bit a_wr [A_DEPTH];
  int cfg_ic = 1, cfg_oc = 1, cfg_k = 3, cfg_pad = 1, cfg_h = 32, cfg_w = 32;
  logic signed [RES_W-1:0] fwd_acc;
  conv_item_t fill_q[$];

  logic signed [RES_W-1:0] expected_q[$];
  int err_count = 0;
  int items_in = 0, results_out = 0, clears_sent = 0, fwd_sent = 0, bwd_sent = 0;
  bit tx_idle_on = 1'b1, rx_idle_on = 1'b1, hold_req = 1'b0;
  int quiet = 0;

  function automatic int lim(int v, int mx);
    return v > mx ? mx : v;
  endfunction

  function automatic int pick(int n);
    return n <= 0 ? 0 : $urandom_range(n - 1);
  endfunction

  function automatic logic signed [RES_W-1:0] sat32(logic signed [RES_W-1:0] a, longint b);
    longint s;
    s = longint'(a) + b;
    if (s > SAT_HI) return 32'sh7fffffff;
    if (s < SAT_LO) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic bit pos_in_range(conv_item_t it);
    return int'(it.oc) < lim(cfg_oc, MAX_OUT_CH) && int'(it.row) < lim(cfg_h, MAX_HEIGHT)
        && int'(it.col) < lim(cfg_w, MAX_WIDTH);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_val();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic walk_taps(conv_item_t it, walk_mode_e m);
    int nic, k, h, w, iy, ix, wi, ai;
    conv_item_t ld;
    nic = lim(cfg_ic, MAX_IN_CH);
    k = lim(cfg_k, MAX_KERNEL);
    h = lim(cfg_h, MAX_HEIGHT);
    w = lim(cfg_w, MAX_WIDTH);
    for (int ic = 0; ic < nic; ic++)
      for (int ky = 0; ky < k; ky++)
        for (int kx = 0; kx < k; kx++) begin
          iy = int'(it.row) + ky - cfg_pad;
          ix = int'(it.col) + kx - cfg_pad;
          if (iy < 0 || ix < 0 || iy >= h || ix >= w) continue;
          wi = ((int'(it.oc) * MAX_IN_CH + ic) * MAX_KERNEL + ky) * MAX_KERNEL + kx;
          ai = (ic * MAX_HEIGHT + iy) * MAX_WIDTH + ix;
          case (m)
            WALK_FWD: fwd_acc = sat32(fwd_acc, longint'(acts_m[ai]) * longint'(weights_m[wi]));
            WALK_BWD: begin
              wgrad_m[wi] = sat32(wgrad_m[wi], longint'(acts_m[ai]) * longint'(it.val));
              xgrad_m[ai] = sat32(xgrad_m[ai], longint'(weights_m[wi]) * longint'(it.val));
            end
            default: begin
              ld = '0;
              if (!w_wr[wi]) begin
                ld.op = OP_LOAD_W; ld.addr = ADDR_W'(wi); ld.val = rand_val();
                fill_q.push_back(ld);
                w_wr[wi] = 1'b1;
              end
              if (!a_wr[ai]) begin
                ld.op = OP_LOAD_A; ld.addr = ADDR_W'(ai); ld.val = rand_val();
                fill_q.push_back(ld);
                a_wr[ai] = 1'b1;
              end
            end
          endcase
        end
  endtask

  // Update the mirror for one accepted beat; has_res tells if a word comes back.
  task automatic predict_item(conv_item_t it, output bit has_res,
                              output logic signed [RES_W-1:0] res);
    int a;
    a = int'(it.addr);
    has_res = 1'b1;
    res = '0;
    case (it.op)
      OP_LOAD_W: begin
        has_res = 1'b0;
        if (a < W_DEPTH) begin weights_m[a] = it.val; w_wr[a] = 1'b1; end
      end
      OP_LOAD_B: begin
        has_res = 1'b0;
        if (a < B_DEPTH) begin bias_m[a] = it.val; b_wr[a] = 1'b1; end
      end
      OP_LOAD_A: begin
        has_res = 1'b0;
        if (a < A_DEPTH) begin acts_m[a] = it.val; a_wr[a] = 1'b1; end
      end
      OP_FORWARD: begin
        if (pos_in_range(it)) begin
          fwd_acc = RES_W'(longint'(bias_m[it.oc]) * 4096);
          walk_taps(it, WALK_FWD);
          res = fwd_acc;
        end
      end
      OP_BACKWARD: begin
        has_res = 1'b0;
        if (pos_in_range(it)) begin
          bgrad_m[it.oc] = sat32(bgrad_m[it.oc], longint'(it.val) * 4096);
          walk_taps(it, WALK_BWD);
        end
      end
      OP_READ_WG: if (a < W_DEPTH) res = wgrad_m[a];
      OP_READ_BG: if (a < B_DEPTH) res = bgrad_m[a];
      default: begin
        if (it.clr) begin
          has_res = 1'b0;
          for (int i = 0; i < W_DEPTH; i++) wgrad_m[i] = '0;
          for (int i = 0; i < B_DEPTH; i++) bgrad_m[i] = '0;
          for (int i = 0; i < A_DEPTH; i++) xgrad_m[i] = '0;
        end else if (a < A_DEPTH) begin
          res = xgrad_m[a];
        end
      end
    endcase
  endtask

  // Entered and left at a falling edge; valid stays high for a following beat.
  task automatic drive_beat(conv_item_t it, bit typed, logic signed [RES_W-1:0] typed_val);
    bit has_res;
    logic signed [RES_W-1:0] res;
    while (tx_idle_on && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.operation <= it.op;
    in_ch.address <= it.addr;
    in_ch.clear_flag <= it.clr;
    in_ch.out_channel <= it.oc;
    in_ch.row <= it.row;
    in_ch.col <= it.col;
    in_ch.value <= it.val;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(it, has_res, res);
    if (has_res) expected_q.push_back(typed ? typed_val : res);
    items_in++;
    if (it.op == OP_READ_XG && it.clr) clears_sent++;
    if (it.op == OP_FORWARD) fwd_sent++;
    if (it.op == OP_BACKWARD) bwd_sent++;
    @(negedge clk_i);
  endtask

  // Load whatever the taps of a forward or backward point would read unwritten.
  task automatic send_item(conv_item_t it, bit typed = 1'b0,
                           logic signed [RES_W-1:0] typed_val = '0);
    conv_item_t ld;
    if ((it.op == OP_FORWARD || it.op == OP_BACKWARD) && pos_in_range(it)) begin
      fill_q.delete();
      if (it.op == OP_FORWARD && !b_wr[it.oc]) begin
        ld = '0; ld.op = OP_LOAD_B; ld.addr = ADDR_W'(it.oc); ld.val = rand_val();
        fill_q.push_back(ld);
      end
      walk_taps(it, WALK_FILL);
      while (fill_q.size() > 0) drive_beat(fill_q.pop_front(), 1'b0, '0);
    end
    drive_beat(it, typed, typed_val);
  endtask

  function automatic conv_item_t rand_item(int span);
    conv_item_t it;
    int nic, noc, k, h, w, r;
    nic = lim(cfg_ic, MAX_IN_CH);
    noc = lim(cfg_oc, MAX_OUT_CH);
    k = lim(cfg_k, MAX_KERNEL);
    h = lim(cfg_h, MAX_HEIGHT);
    w = lim(cfg_w, MAX_WIDTH);
    it = '0;
    it.val = rand_val();
    it.clr = 1'($urandom_range(1));
    if ($urandom_range(99) < 85) begin
      it.oc = OC_W'(pick(lim(noc, span)));
      it.row = ROW_W'(pick(lim(h, span + 2)));
      it.col = COL_W'(pick(lim(w, span + 2)));
    end else begin
      it.oc = OC_W'($urandom); it.row = ROW_W'($urandom); it.col = COL_W'($urandom);
    end
    r = $urandom_range(99);
    if (r < 12) begin
      it.op = OP_LOAD_W;
      it.addr = ADDR_W'(((pick(noc) * MAX_IN_CH + pick(nic)) * MAX_KERNEL + pick(k))
                        * MAX_KERNEL + pick(k));
    end else if (r < 17) begin
      it.op = OP_LOAD_B; it.addr = ADDR_W'(pick(noc));
    end else if (r < 32) begin
      it.op = OP_LOAD_A;
      it.addr = ADDR_W'((pick(nic) * MAX_HEIGHT + pick(h)) * MAX_WIDTH + pick(w));
    end else if (r < 57) begin
      it.op = OP_FORWARD;
    end else if (r < 77) begin
      it.op = OP_BACKWARD;
    end else if (r < 83) begin
      it.op = OP_READ_WG;
      it.addr = ADDR_W'(((pick(noc) * MAX_IN_CH + pick(nic)) * MAX_KERNEL + pick(k))
                        * MAX_KERNEL + pick(k));
    end else if (r < 88) begin
      it.op = OP_READ_BG; it.addr = ADDR_W'(pick(noc));
    end else if (r < 96) begin
      it.op = OP_READ_XG; it.clr = 1'b0;
      it.addr = ADDR_W'((pick(nic) * MAX_HEIGHT + pick(h)) * MAX_WIDTH + pick(w));
    end else if (r < 97) begin
      it.op = OP_READ_XG; it.clr = 1'b1;
    end else begin
      // noise: any operation, any address
      it.op = OP_W'($urandom);
      if (it.op == OP_READ_XG) it.clr = 1'b0;
    end
    // reach out-of-range and high address bits now and then
    if (it.op != OP_FORWARD && it.op != OP_BACKWARD && $urandom_range(99) < 20)
      it.addr = ADDR_W'($urandom);
    return it;
  endfunction

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_DATA_W'(data);
    @(negedge clk_i);
    case (idx)
      CFG_IN_CH:  cfg_ic = data & 5'h1f;
      CFG_OUT_CH: cfg_oc = data & 5'h1f;
      CFG_KSIZE:  cfg_k = data & 3'h7;
      CFG_PAD:    cfg_pad = data & 3'h7;
      CFG_HEIGHT: cfg_h = data & 6'h3f;
      default:    cfg_w = data & 6'h3f;
    endcase
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk_i);
    // a clear or a backward point can still be running with nothing to return
    repeat (IDLE_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(string what, logic signed [RES_W-1:0] got,
                                 logic signed [RES_W-1:0] want);
    err_count++;
    $display("MISMATCH %s: got %0d (0x%08h) want %0d (0x%08h) at %0t",
             what, got, got, want, want, $realtime);
  endtask

  function automatic conv_item_t mk(logic [OP_W-1:0] op, int addr, bit clr, int oc, int row,
                                    int col, int val);
    conv_item_t it;
    it.op = op; it.addr = ADDR_W'(addr); it.clr = clr; it.oc = OC_W'(oc);
    it.row = ROW_W'(row); it.col = COL_W'(col); it.val = VAL_W'(val);
    return it;
  endfunction

  // Result checker.
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      results_out++;
      if (expected_q.size() == 0) report_mismatch("unexpected result", out_ch.result_value, '0);
      else begin
        logic signed [RES_W-1:0] want;
        want = expected_q.pop_front();
        if (out_ch.result_value !== want)
          report_mismatch("result_value", out_ch.result_value, want);
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rx_idle_on ? ($urandom_range(99) >= 13) : 1'b1;
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    table_row_t dir_tbl[$];
    phase_t phases[$];
    table_row_t tr;
    phase_t ph;
    int n;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_LOAD_W;
    in_ch.address = '0;
    in_ch.clear_flag = 1'b0;
    in_ch.out_channel = '0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.value = '0;
    for (int i = 0; i < W_DEPTH; i++) begin wgrad_m[i] = '0; w_wr[i] = 1'b0; end
    for (int i = 0; i < B_DEPTH; i++) begin bgrad_m[i] = '0; b_wr[i] = 1'b0; end
    for (int i = 0; i < A_DEPTH; i++) begin xgrad_m[i] = '0; a_wr[i] = 1'b0; end

    // Directed rows under the reset configuration (1 in, 1 out, 3x3, pad 1, 32x32).
    tr.typed = 1'b1; tr.typed_val = '0;
    tr.it = mk(OP_READ_WG, 0, 0, 0, 0, 0, 0); dir_tbl.push_back(tr);
    tr.it = mk(OP_READ_BG, 0, 0, 0, 0, 0, 0); dir_tbl.push_back(tr);
    tr.it = mk(OP_READ_XG, 16383, 0, 0, 0, 0, 0); dir_tbl.push_back(tr);
    tr.it = mk(OP_READ_WG, 16383, 0, 0, 0, 0, 0); dir_tbl.push_back(tr);
    tr.it = mk(OP_READ_BG, 16, 0, 0, 0, 0, 0); dir_tbl.push_back(tr);
    tr.typed = 1'b0;
    tr.it = mk(OP_LOAD_B, 0, 0, 0, 0, 0, 32767); dir_tbl.push_back(tr);
    tr.it = mk(OP_LOAD_W, 6, 0, 0, 0, 0, -32768); dir_tbl.push_back(tr);
    tr.it = mk(OP_LOAD_W, 7, 0, 0, 0, 0, -32768); dir_tbl.push_back(tr);
    tr.it = mk(OP_LOAD_W, 11, 0, 0, 0, 0, -32768); dir_tbl.push_back(tr);
    tr.it = mk(OP_LOAD_W, 12, 0, 0, 0, 0, -32768); dir_tbl.push_back(tr);
    tr.it = mk(OP_LOAD_A, 0, 0, 0, 0, 0, -32768); dir_tbl.push_back(tr);
    tr.it = mk(OP_LOAD_A, 1, 0, 0, 0, 0, -32768); dir_tbl.push_back(tr);
    tr.it = mk(OP_LOAD_A, 32, 0, 0, 0, 0, -32768); dir_tbl.push_back(tr);
    tr.it = mk(OP_LOAD_A, 33, 0, 0, 0, 0, -32768); dir_tbl.push_back(tr);
    tr.it = mk(OP_LOAD_W, 16383, 0, 0, 0, 0, 1234); dir_tbl.push_back(tr);
    // corner point: four full-scale products saturate high
    tr.typed = 1'b1; tr.typed_val = 32'sh7fffffff;
    tr.it = mk(OP_FORWARD, 0, 0, 0, 0, 0, 0); dir_tbl.push_back(tr);
    tr.typed_val = '0;
    tr.it = mk(OP_FORWARD, 0, 0, 1, 0, 0, 0); dir_tbl.push_back(tr);
    tr.typed = 1'b0;
    tr.it = mk(OP_BACKWARD, 0, 0, 0, 0, 0, 32767); dir_tbl.push_back(tr);
    tr.it = mk(OP_BACKWARD, 0, 0, 15, 0, 0, -32768); dir_tbl.push_back(tr);
    tr.it = mk(OP_READ_BG, 0, 0, 0, 0, 0, 0); dir_tbl.push_back(tr);
    tr.it = mk(OP_READ_WG, 6, 0, 0, 0, 0, 0); dir_tbl.push_back(tr);
    tr.it = mk(OP_READ_XG, 33, 0, 0, 0, 0, 0); dir_tbl.push_back(tr);
    tr.it = mk(OP_READ_XG, 0, 1, 0, 0, 0, 0); dir_tbl.push_back(tr);
    tr.typed = 1'b1; tr.typed_val = '0;
    tr.it = mk(OP_READ_BG, 0, 0, 0, 0, 0, 0); dir_tbl.push_back(tr);

    // Random phases: in, out, kernel, pad, height, width, items, span, idling.
    phases.push_back('{1, 1, 3, 1, 32, 32, 40, 3, 1'b1});
    phases.push_back('{2, 2, 3, 1, 4, 4, 60, 4, 1'b1});
    phases.push_back('{1, 1, 1, 0, 1, 1, 30, 1, 1'b0});
    phases.push_back('{4, 16, 5, 4, 32, 32, 40, 1, 1'b1});
    phases.push_back('{31, 31, 7, 7, 63, 63, 40, 1, 1'b1});
    phases.push_back('{0, 0, 0, 0, 0, 0, 20, 2, 1'b1});
    phases.push_back('{3, 4, 2, 0, 5, 7, 60, 5, 1'b1});
    phases.push_back('{1, 3, 5, 2, 8, 8, 60, 6, 1'b1});

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tbl[i]) send_item(dir_tbl[i].it, dir_tbl[i].typed, dir_tbl[i].typed_val);

    foreach (phases[p]) begin
      ph = phases[p];
      wait_idle();
      write_reg(CFG_IN_CH, ph.ic);
      write_reg(CFG_OUT_CH, ph.oc);
      write_reg(CFG_KSIZE, ph.k);
      write_reg(CFG_PAD, ph.pad);
      write_reg(CFG_HEIGHT, ph.h);
      write_reg(CFG_WIDTH, ph.w);
      cfg_we_i <= 1'b0;
      tx_idle_on = ph.idle;
      rx_idle_on = ph.idle;
      n = 0;
      while (n < ph.n_items) begin
        // hold the receiver off once so the block fills and stalls its input
        if (p == 1 && n == 20) hold_req = 1'b1;
        send_item(rand_item(ph.span));
        n++;
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    $display("Ran %0d beats in %0d configurations: %0d forward, %0d backward, %0d clears.",
             items_in, phases.size() + 1, fwd_sent, bwd_sent, clears_sent);
    $display("Checked %0d result words, %0d mismatches.", results_out, err_count);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
